// ===== rtl/core/mxs2h_pkg.sv =====
package mxs2h_pkg;

    localparam int ValueW  = 8;
    localparam int ScaleW  = 8;
    localparam int HalfW   = 16;
    localparam int StatusW = 2;
    localparam int InDataW = 16;
    localparam int OutDataW = 24;

    typedef enum logic [StatusW-1:0] {
        ST_OK            = 2'd0,
        ST_INVALID_SCALE = 2'd1,
        ST_NAN_VALUE     = 2'd2
    } t_status;

    // decoded element: m in 0..15, exponent of lsb in signed 10 bits
    typedef struct packed {
        logic              sign;
        logic [3:0]        mant;
        logic signed [9:0] expo;
        t_status           status;
    } t_dec;

    // normalized: top bit position and shift amount for subnormal path
    typedef struct packed {
        logic              sign;
        logic [3:0]        mant;
        logic [1:0]        msb;
        logic signed [9:0] top;
        logic signed [9:0] sub_sh;
        t_status           status;
    } t_norm;

    typedef struct packed {
        logic [HalfW-1:0] half_bits;
        t_status          status;
    } t_res;

endpackage

// ===== rtl/core/mxs2h_decode.sv =====
module mxs2h_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [mxs2h_pkg::ValueW-1:0]  i_value,
    input  logic [mxs2h_pkg::ScaleW-1:0]  i_scale,
    output logic                          o_valid,
    output mxs2h_pkg::t_dec               o_dec
);
    mxs2h_pkg::t_dec n_dec;
    mxs2h_pkg::t_dec r_dec;
    logic            r_valid;
    logic [3:0]      w_ex;

    always_comb begin
        w_ex         = i_value[6:3];
        n_dec.sign   = i_value[7];
        n_dec.status = mxs2h_pkg::ST_OK;
        if (i_scale == 8'hff) begin
            n_dec.status = mxs2h_pkg::ST_INVALID_SCALE;
        end else if (i_value[6:0] == 7'h7f) begin
            n_dec.status = mxs2h_pkg::ST_NAN_VALUE;
        end
        if (w_ex == 4'd0) begin
            n_dec.mant = {1'b0, i_value[2:0]};
            n_dec.expo = 10'(signed'(-9 - 127)) + signed'({2'b00, i_scale});
        end else begin
            n_dec.mant = {1'b1, i_value[2:0]};
            n_dec.expo = signed'({6'd0, w_ex}) - 10'sd137 + signed'({2'b00, i_scale});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

// ===== rtl/core/mxs2h_norm.sv =====
module mxs2h_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  mxs2h_pkg::t_dec  i_dec,
    output logic             o_valid,
    output mxs2h_pkg::t_norm o_norm
);
    mxs2h_pkg::t_norm n_norm;
    mxs2h_pkg::t_norm r_norm;
    logic             r_valid;

    always_comb begin
        n_norm.sign   = i_dec.sign;
        n_norm.mant   = i_dec.mant;
        n_norm.status = i_dec.status;
        if (i_dec.mant[3]) begin
            n_norm.msb = 2'd3;
        end else if (i_dec.mant[2]) begin
            n_norm.msb = 2'd2;
        end else if (i_dec.mant[1]) begin
            n_norm.msb = 2'd1;
        end else begin
            n_norm.msb = 2'd0;
        end
        n_norm.top    = i_dec.expo + signed'({8'd0, n_norm.msb});
        n_norm.sub_sh = i_dec.expo + 10'sd24;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_norm <= n_norm;
        end
    end

    assign o_valid = r_valid;
    assign o_norm  = r_norm;
endmodule

// ===== rtl/core/mxs2h_encode.sv =====
module mxs2h_encode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  mxs2h_pkg::t_norm i_norm,
    output logic             o_valid,
    output mxs2h_pkg::t_res  o_res
);
    mxs2h_pkg::t_res n_res;
    mxs2h_pkg::t_res r_res;
    logic            r_valid;
    logic [14:0]     w_mag;
    logic [13:0]     w_frac;
    logic [2:0]      w_k;
    logic [3:0]      w_q;
    logic [3:0]      w_rem;
    logic [3:0]      w_halfway;

    always_comb begin
        w_frac    = 14'({i_norm.mant, 10'd0} >> i_norm.msb);
        w_k       = 3'd0;
        w_q       = 4'd0;
        w_rem     = 4'd0;
        w_halfway = 4'd0;
        if (i_norm.mant == 4'd0) begin
            w_mag = 15'd0;
        end else if (i_norm.top > 10'sd15) begin
            w_mag = 15'h7c00;
        end else if (i_norm.top >= -10'sd14) begin
            w_mag = {5'(i_norm.top + 10'sd15), w_frac[9:0]};
        end else if (i_norm.sub_sh >= 10'sd0) begin
            w_mag = 15'({11'd0, i_norm.mant} << i_norm.sub_sh[3:0]);
        end else if (i_norm.sub_sh <= -10'sd5) begin
            w_mag = 15'd0;
        end else begin
            w_k       = 3'(-i_norm.sub_sh);
            w_q       = i_norm.mant >> w_k;
            w_rem     = i_norm.mant & 4'((5'd1 << w_k) - 5'd1);
            w_halfway = 4'(5'd1 << (w_k - 3'd1));
            if (w_rem > w_halfway || (w_rem == w_halfway && w_q[0])) begin
                w_q = w_q + 4'd1;
            end
            w_mag = {11'd0, w_q};
        end
        n_res.status = i_norm.status;
        if (i_norm.status != mxs2h_pkg::ST_OK) begin
            n_res.half_bits = 16'd0;
        end else begin
            n_res.half_bits = {i_norm.sign, w_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== rtl/core/mxfp8_e4m3_scaled_to_half_unit.sv =====
// pipeline: registered decode, norm and encode stages between input transfer and output transfer
// throughput: one transfer per cycle, the three stages stall together
// reset: synchronous active-low i_rst_n clears all stage valid bits
module mxfp8_e4m3_scaled_to_half_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mxs2h_pkg::InDataW-1:0]     s_axis_tdata,  // value_byte, scale_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mxs2h_pkg::OutDataW-1:0]    m_axis_tdata   // half_bits, status, pad
);
    logic             w_en;
    logic             w_v1;
    logic             w_v2;
    mxs2h_pkg::t_dec  w_dec;
    mxs2h_pkg::t_norm w_norm;
    mxs2h_pkg::t_res  w_res;

    assign w_en          = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    mxs2h_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_value (s_axis_tdata[7:0]),
        .i_scale (s_axis_tdata[15:8]),
        .o_valid (w_v1),
        .o_dec   (w_dec)
    );

    mxs2h_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_dec   (w_dec),
        .o_valid (w_v2),
        .o_norm  (w_norm)
    );

    mxs2h_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v2),
        .i_norm  (w_norm),
        .o_valid (m_axis_tvalid),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.status, w_res.half_bits};
endmodule

// ===== rtl/core/mxs2h_checker.sv =====
module mxs2h_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
        else $error("bad status");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] != mxs2h_pkg::ST_OK
        |-> m_axis_tdata[15:0] == 16'd0)
        else $error("nonzero half on error");
    a_bad_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[15:8] == 8'hff && m_axis_tready)
        ##1 m_axis_tready [*2]
        |=> m_axis_tvalid && m_axis_tdata[17:16] == mxs2h_pkg::ST_INVALID_SCALE)
        else $error("invalid scale not flagged");
endmodule

bind mxfp8_e4m3_scaled_to_half_unit mxs2h_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    typedef struct packed {
        logic [mxs2h_pkg::HalfW-1:0] half_bits;
        mxs2h_pkg::t_status          status;
    } t_expect;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [mxs2h_pkg::InDataW-1:0]  s_axis_tdata;   // value_byte, scale_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mxs2h_pkg::OutDataW-1:0] m_axis_tdata;   // half_bits, status, pad

    logic [mxs2h_pkg::InDataW-1:0] pending_elems[$];
    t_expect                       expected_halves[$];
    int                            errors = 0;
    int                            cycles = 0;
    int                            send_gap = 0;
    int                            recv_gap = 0;
    int                            hold_off = 0;

    mxfp8_e4m3_scaled_to_half_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // encode m * 2^e as a binary16 magnitude, m in 1..15
    function automatic logic [14:0] half_magnitude(input int m, input int e);
        int p;
        int top;
        int k;
        int q;
        int rem;
        int halfway;
        p = 0;
        while ((m >> (p + 1)) != 0) p++;
        top = e + p;
        if (top > 15) return 15'h7C00;
        if (top >= -14) return 15'((top + 15) << 10) | 15'((m << (10 - p)) & 10'h3FF);
        if (e + 24 >= 0) return 15'(m << (e + 24));
        k = -(e + 24);
        if (k >= 5) return 15'd0;
        q = m >> k;
        rem = m & ((1 << k) - 1);
        halfway = 1 << (k - 1);
        if (rem > halfway || (rem == halfway && q[0])) q++;
        return 15'(q);
    endfunction

    function automatic t_expect dequant_elem(input logic [7:0] v, input logic [7:0] s);
        t_expect r;
        int m;
        int e;
        r = '0;
        r.status = mxs2h_pkg::ST_OK;
        if (s == 8'hFF) begin
            r.status = mxs2h_pkg::ST_INVALID_SCALE;
        end else if (v[6:0] == 7'h7F) begin
            r.status = mxs2h_pkg::ST_NAN_VALUE;
        end else begin
            if (v[6:3] == 4'd0) begin
                m = v[2:0];
                e = -9;
            end else begin
                m = 8 + v[2:0];
                e = int'(v[6:3]) - 10;
            end
            e += int'(s) - 127;
            r.half_bits = {v[7], (m == 0) ? 15'd0 : half_magnitude(m, e)};
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 4) return $urandom_range(8, 30);
        if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
        return 0;
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // driver
    initial begin
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_halves.insert(expected_halves.size(),
                    dequant_elem(s_axis_tdata[7:0], s_axis_tdata[15:8]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0 || pending_elems.size() == 0) begin
                    s_axis_tvalid <= 0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    s_axis_tvalid <= 1;
                    s_axis_tdata <= pending_elems[0];
                    pending_elems.delete(0);
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // monitor
    initial m_axis_tready = 0;
    always @(posedge i_clk) begin
        t_expect want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_halves.size() == 0) begin
                    $error("unexpected transfer %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_halves[0];
                    expected_halves.delete(0);
                    if (m_axis_tdata[15:0] !== want.half_bits) begin
                        $error("half_bits exp %h got %h", want.half_bits, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[17:16] !== want.status) begin
                        $error("status exp %0d got %0d", want.status, m_axis_tdata[17:16]);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
                recv_gap <= pick_gap();
            end
        end
    end

    task automatic add_elem(input logic [7:0] v, input logic [7:0] s);
        pending_elems.insert(pending_elems.size(), {s, v});
    endtask

    task automatic wait_drained();
        while (pending_elems.size() != 0 || s_axis_tvalid || expected_halves.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] v;
        logic [7:0] s;
        @(posedge i_rst_n);
        add_elem(8'h00, 8'd127);
        add_elem(8'h80, 8'd127);
        add_elem(8'h7E, 8'd127);
        add_elem(8'hFE, 8'd142);
        add_elem(8'h7E, 8'd254);
        add_elem(8'h7F, 8'd127);
        add_elem(8'hFF, 8'd0);
        add_elem(8'h7F, 8'hFF);
        add_elem(8'h38, 8'hFF);
        add_elem(8'h01, 8'd0);
        add_elem(8'h81, 8'd112);
        add_elem(8'h01, 8'd112);
        add_elem(8'h07, 8'd113);
        add_elem(8'h05, 8'd110);
        add_elem(8'h03, 8'd111);
        add_elem(8'h0F, 8'd108);
        add_elem(8'h38, 8'd143);
        add_elem(8'h38, 8'd142);
        add_elem(8'h2A, 8'd100);
        add_elem(8'hAA, 8'd105);
        wait_drained();
        for (int i = 0; i < 1400; i++) begin
            v = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 80) s = 8'($urandom_range(95, 160));
            else s = 8'($urandom_range(0, 255));
            add_elem(v, s);
            if (i == 300) begin
                while (pending_elems.size() != 0) @(posedge i_clk);
                hold_off = 60;
            end
            if (i == 700) wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
